@@ rtl/opsl_pkg.sv @@
`timescale 1ns / 1ps

package opsl_pkg;

    // default sizes, overridable on the top level
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int FRAME_BITS_DEF  = 11;

    // break detection thresholds
    localparam logic [7:0] BREAK_RUN = 8'd21;
    localparam logic [7:0] RUN_MAX   = 8'd255;

    // receiver frame positions
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_DATA_L = 4'd8;
    localparam logic [3:0] PH_PARITY = 4'd9;

    // transmitter frame positions
    localparam logic [3:0] TX_START  = 4'd0;
    localparam logic [3:0] TX_DATA_L = 4'd8;
    localparam logic [3:0] TX_PARITY = 4'd9;

    // request command codes
    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TX_BIT = 2'd1,
        CMD_ENQ    = 2'd2
    } t_cmd;

    // receiver side of one result
    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       rx_parity_ok;
        logic       break_seen;
    } t_rx_res;

    // full result of one request
    typedef struct packed {
        t_rx_res rx;
        logic    tx_level;
        logic    overflow;
    } t_result;

endpackage

@@ rtl/odd_parity_serial_link_with_break_top.sv @@
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------------
// request   | i_valid / o_ready  | i_command, i_line_level, i_send_byte
// result    | o_valid / i_ready  | o_rx_valid, o_rx_data, o_rx_parity_ok,
//           |                    | o_break_seen, o_tx_level, o_overflow
//
// One request per cycle while o_ready is high; its result goes into the output
// register, or the skid register if stalled. The head byte is prefetched from
// the queue storage each cycle, so command 1 uses registered read data.
// A skid register holds one more result, so a stalled output costs no request
// until both are full; o_ready then drops.
// Reset clears all control state; o_ready is low while reset is held.
// Queue storage is not cleared; entries are read only after they are written.

module odd_parity_serial_link_with_break_top
    import opsl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_command,
    input  logic       i_line_level,
    input  logic [7:0] i_send_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_rx_valid,
    output logic [7:0] o_rx_data,
    output logic       o_rx_parity_ok,
    output logic       o_break_seen,
    output logic       o_tx_level,
    output logic       o_overflow
);

    logic    accept, take;
    logic    rx_en;
    t_rx_res rx_res;
    t_result res;
    logic    r_ready;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, r_skid;

    assign accept = i_valid && o_ready;
    assign take   = o_valid && i_ready;
    assign rx_en  = accept && (i_command == CMD_SAMPLE);

    // receiver and break detector
    opsl_rx u_rx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (rx_en),
        .i_level (i_line_level),
        .o_res   (rx_res)
    );

    // response queue and transmitter
    opsl_txq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .FRAME_BITS  (FRAME_BITS)
    ) u_txq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_cmd      (i_command),
        .i_byte     (i_send_byte),
        .i_clear    (rx_res.break_seen),
        .o_tx_level (res.tx_level),
        .o_overflow (res.overflow)
    );

    assign res.rx = rx_res;

    // output register with skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (take) begin
                n_skid_valid = 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !take) begin
                n_skid_valid = 1'b1;
            end
            n_out_valid = 1'b1;
        end else if (take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
            r_ready      <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
            r_ready      <= !n_skid_valid;
        end
    end

    assign o_ready        = r_ready;
    assign o_valid        = r_out_valid;
    assign o_rx_valid     = r_out.rx.rx_valid;
    assign o_rx_data      = r_out.rx.rx_data;
    assign o_rx_parity_ok = r_out.rx.rx_parity_ok;
    assign o_break_seen   = r_out.rx.break_seen;
    assign o_tx_level     = r_out.tx_level;
    assign o_overflow     = r_out.overflow;

    // skid holds a result only behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid valid with empty output register");

    // ready follows the skid occupancy once out of reset
    a_ready_tracks_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (o_ready == !r_skid_valid))
        else $error("ready out of step with skid stage");

    // a break never delivers a byte
    a_break_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_break_seen && o_rx_valid))
        else $error("break and received byte in one result");

    // line sample and enqueue overflow results keep the response line idle high
    a_rx_tx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rx_valid || o_break_seen || o_overflow)) |-> o_tx_level)
        else $error("response line driven low outside a bit request");

endmodule

@@ rtl/opsl_rx.sv @@
`timescale 1ns / 1ps

module opsl_rx
    import opsl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_level,
    output t_rx_res o_res
);

    logic [3:0] r_phase, n_phase;
    logic [7:0] r_shift, n_shift;
    logic       r_acc, n_acc;
    logic [7:0] r_low_run, n_low_run;
    logic       r_latch, n_latch;
    logic [7:0] low_inc;
    logic       latch_pre;

    // low run counter, saturating
    assign low_inc   = (r_low_run < RUN_MAX) ? r_low_run + 8'd1 : r_low_run;
    assign latch_pre = i_level ? 1'b0 : r_latch;

    // frame reception and break detection
    always_comb begin
        n_phase   = r_phase;
        n_shift   = r_shift;
        n_acc     = r_acc;
        n_low_run = r_low_run;
        n_latch   = r_latch;
        o_res     = '0;
        if (i_en) begin
            n_low_run = i_level ? 8'd0 : low_inc;
            n_latch   = latch_pre;
            if (n_low_run >= BREAK_RUN && !latch_pre) begin
                n_phase          = PH_IDLE;
                n_shift          = '0;
                n_acc            = 1'b0;
                n_low_run        = BREAK_RUN;
                n_latch          = 1'b1;
                o_res.break_seen = 1'b1;
            end else if (!latch_pre) begin
                if (r_phase == PH_IDLE) begin
                    if (!i_level) begin
                        n_phase = 4'd1;
                        n_shift = '0;
                        n_acc   = 1'b0;
                    end
                end else if (r_phase <= PH_DATA_L) begin
                    n_shift[3'(r_phase - 4'd1)] = r_shift[3'(r_phase - 4'd1)] | i_level;
                    n_acc   = r_acc ^ i_level;
                    n_phase = r_phase + 4'd1;
                end else if (r_phase == PH_PARITY) begin
                    n_acc   = r_acc ^ i_level;
                    n_phase = r_phase + 4'd1;
                end else begin
                    // stop bit: deliver only when high
                    if (i_level) begin
                        o_res.rx_valid     = 1'b1;
                        o_res.rx_data      = r_shift;
                        o_res.rx_parity_ok = r_acc;
                    end
                    n_phase = PH_IDLE;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_shift   <= '0;
            r_acc     <= 1'b0;
            r_low_run <= '0;
            r_latch   <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_shift   <= n_shift;
            r_acc     <= n_acc;
            r_low_run <= n_low_run;
            r_latch   <= n_latch;
        end
    end

endmodule

@@ rtl/opsl_txq.sv @@
`timescale 1ns / 1ps

module opsl_txq
    import opsl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_byte,
    input  logic       i_clear,
    output logic       o_tx_level,
    output logic       o_overflow
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

    logic [7:0]    r_mem [QUEUE_DEPTH];
    logic [7:0]    r_rd_data;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [3:0]    r_idx, n_idx;
    logic [PW-1:0] head_nxt, tail_nxt;
    logic [4:0]    idx_inc;
    logic          empty, full, wr;

    assign head_nxt = (r_head == LAST) ? '0 : r_head + PW'(1);
    assign tail_nxt = (r_tail == LAST) ? '0 : r_tail + PW'(1);
    assign empty    = (r_head == r_tail);
    assign full     = (tail_nxt == r_head);
    assign idx_inc  = {1'b0, r_idx} + 5'd1;

    // bit shifting, enqueueing and clearing on a break
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_idx      = r_idx;
        o_tx_level = 1'b1;
        o_overflow = 1'b0;
        wr         = 1'b0;
        if (i_en) begin
            if (i_clear) begin
                n_head = '0;
                n_tail = '0;
                n_idx  = '0;
            end else begin
                case (i_cmd)
                    CMD_TX_BIT: begin
                        if (!empty) begin
                            if (r_idx == TX_START) begin
                                o_tx_level = 1'b0;
                            end else if (r_idx <= TX_DATA_L) begin
                                o_tx_level = r_rd_data[3'(r_idx - 4'd1)];
                            end else if (r_idx == TX_PARITY) begin
                                o_tx_level = ~^r_rd_data;
                            end
                            if (idx_inc >= 5'(FRAME_BITS)) begin
                                n_idx  = '0;
                                n_head = head_nxt;
                            end else begin
                                n_idx = idx_inc[3:0];
                            end
                        end
                    end
                    CMD_ENQ: begin
                        if (full) begin
                            o_overflow = 1'b1;
                        end else begin
                            wr     = 1'b1;
                            n_tail = tail_nxt;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // queue storage, head entry read ahead with write bypass
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_tail] <= i_byte;
        end
        r_rd_data <= (wr && r_tail == n_head) ? i_byte : r_mem[n_head];
    end

    // pointers and bit index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_idx  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_idx  <= n_idx;
        end
    end

endmodule
